// ===== rtl/blic_pkg.sv =====
// Package for the backlight blink and idle controller.
// Holds widths, event and register codes, and the shared structs.
// No dependencies.
package blic_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned DUR_W       = 16;
  localparam int unsigned BLINK_COUNT = 3;
  localparam int unsigned PHASE_END   = 2 * BLINK_COUNT;
  localparam int unsigned PHASE_W     = $clog2(PHASE_END + 1);
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = TIME_W;

  // Input word layout in tdata, lowest bit first.
  localparam int unsigned IN_BITS   = TIME_W + 1 + TIME_W + KIND_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = 3;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    MODE_TIME  = 2'd0,
    MODE_BLINK = 2'd1,
    MODE_WAKE  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_TIMEOUT = 2'd0,
    REG_BLINK_ON     = 2'd1,
    REG_BLINK_LONG   = 2'd2,
    REG_BLINK_PAUSE  = 2'd3
  } cfg_reg_e;

  localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST = TIME_W'(60000);
  localparam logic [DUR_W-1:0]  BLINK_ON_RST     = DUR_W'(300);
  localparam logic [DUR_W-1:0]  BLINK_LONG_RST   = DUR_W'(800);
  localparam logic [DUR_W-1:0]  BLINK_PAUSE_RST  = DUR_W'(300);

  typedef struct packed {
    logic [TIME_W-1:0] idle_timeout;
    logic [DUR_W-1:0]  blink_on;
    logic [DUR_W-1:0]  blink_long_on;
    logic [DUR_W-1:0]  blink_pause;
  } blic_cfg_t;

  typedef struct packed {
    mode_e             mode;
    logic [TIME_W-1:0] now_ms;
    logic              control_active;
    logic [TIME_W-1:0] last_activity_ms;
    logic [KIND_W-1:0] pattern;
  } blic_item_t;

  typedef struct packed {
    logic               lit;
    logic               blinking;
    logic               dark_from_idle;
    logic [KIND_W-1:0]  blink_kind;
    logic [PHASE_W-1:0] phase_count;
    logic [TIME_W-1:0]  next_phase_time;
  } blic_state_t;

endpackage

// ===== rtl/blic_cfg.sv =====
// Configuration register file of the backlight controller.
// Depends on blic_pkg.
module blic_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [blic_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [blic_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output blic_pkg::blic_cfg_t                cfg_o
);
  import blic_pkg::*;

  blic_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IDLE_TIMEOUT: cfg_d.idle_timeout  = cfg_data_i[TIME_W-1:0];
        REG_BLINK_ON:     cfg_d.blink_on      = cfg_data_i[DUR_W-1:0];
        REG_BLINK_LONG:   cfg_d.blink_long_on = cfg_data_i[DUR_W-1:0];
        REG_BLINK_PAUSE:  cfg_d.blink_pause   = cfg_data_i[DUR_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_timeout  <= IDLE_TIMEOUT_RST;
      cfg_q.blink_on      <= BLINK_ON_RST;
      cfg_q.blink_long_on <= BLINK_LONG_RST;
      cfg_q.blink_pause   <= BLINK_PAUSE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/blic_step.sv =====
// Next-state logic of the backlight controller for one event.
// Depends on blic_pkg.
module blic_step (
  input  blic_pkg::blic_cfg_t   cfg_i,
  input  blic_pkg::blic_item_t  item_i,
  input  blic_pkg::blic_state_t state_i,
  output blic_pkg::blic_state_t state_o
);
  import blic_pkg::*;

  logic [TIME_W-1:0] phase_diff;
  logic [TIME_W-1:0] idle_elapsed;
  logic              idle_expired;
  logic [DUR_W-1:0]  phase_len;
  logic              seq_done;

  // A negative wrapped difference means the phase time still lies ahead.
  assign phase_diff   = item_i.now_ms - state_i.next_phase_time;
  assign idle_elapsed = item_i.now_ms - item_i.last_activity_ms;
  assign idle_expired = (idle_elapsed >= cfg_i.idle_timeout);
  assign seq_done     = (state_i.phase_count >= PHASE_W'(PHASE_END));

  // Even phases are lit; the out-of-target and mains-absent kinds have odd codes
  // and use the long on time.
  always_comb begin
    if (state_i.phase_count[0]) begin
      phase_len = cfg_i.blink_pause;
    end else if (state_i.blink_kind[0]) begin
      phase_len = cfg_i.blink_long_on;
    end else begin
      phase_len = cfg_i.blink_on;
    end
  end

  always_comb begin
    state_o = state_i;
    unique case (item_i.mode)
      MODE_TIME: begin
        if (state_i.blinking) begin
          if (!phase_diff[TIME_W-1]) begin
            if (seq_done) begin
              state_o.blinking   = 1'b0;
              state_o.blink_kind = '0;
              if (!item_i.control_active && idle_expired) begin
                state_o.dark_from_idle = 1'b1;
                state_o.lit            = 1'b0;
              end else begin
                state_o.dark_from_idle = 1'b0;
                state_o.lit            = 1'b1;
              end
            end else begin
              state_o.lit             = ~state_i.phase_count[0];
              state_o.next_phase_time = item_i.now_ms
                                        + {{(TIME_W-DUR_W){1'b0}}, phase_len};
              state_o.phase_count     = state_i.phase_count + PHASE_W'(1);
            end
          end
        end else if (item_i.control_active) begin
          state_o.dark_from_idle = 1'b0;
          state_o.lit            = 1'b1;
        end else if (idle_expired) begin
          if (!state_i.dark_from_idle) begin
            state_o.dark_from_idle = 1'b1;
            state_o.lit            = 1'b0;
          end
        end else if (!state_i.dark_from_idle) begin
          state_o.lit = 1'b1;
        end
      end
      MODE_BLINK: begin
        state_o.blink_kind      = item_i.pattern;
        state_o.phase_count     = '0;
        state_o.blinking        = 1'b1;
        state_o.dark_from_idle  = 1'b0;
        state_o.next_phase_time = item_i.now_ms;
      end
      MODE_WAKE: begin
        state_o.dark_from_idle = 1'b0;
        if (!state_i.blinking) begin
          state_o.lit = 1'b1;
        end
      end
      MODE_NONE: begin
        state_o = state_i;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// ===== rtl/backlight_blink_idle_controller_top.sv =====
// Top level of the backlight blink and idle controller.
// Depends on blic_pkg, blic_cfg and blic_step.
//
// Use: events enter on the s_axis channel, one word each. tuser carries the
// event kind (time update, start blink, activity notice); tdata carries the
// time, control status, last activity time and blink pattern. Every event
// gives one result word on the m_axis channel with the backlight drive, the
// blink-busy flag and the idle-dark flag.
// An accepted word sits in an input register; once the output register is
// free or drained, the state update runs and the result is written to the
// output register, which offers it to the receiver on the m_axis channel.
// Throughput is one event per cycle unless the receiver stalls: the state
// update is combinational, from input register to state and output registers.
// When the receiver stalls, the output register holds its word and one more
// event may wait in the input register; then s_axis_tready drops.
// The configuration port writes durations and the idle timeout; write it only
// while no events are in flight. Reset returns all timings to their defaults,
// lights the backlight and stops any blink sequence.
module backlight_blink_idle_controller_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input words.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0: now_ms[32], control_active[1], last_activity_ms[32],
  // pattern[2], zero fill.
  input  logic [blic_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: mode[2].
  input  logic [1:0]                          s_axis_tuser,
  // Result words.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata from bit 0: backlight_on[1], blink_busy[1], idle_dark[1], zero fill.
  output logic [blic_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // Configuration writes.
  input  logic                                cfg_we_i,
  input  logic [blic_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [blic_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import blic_pkg::*;

  blic_cfg_t   cfg;
  blic_item_t  item_q, item_d;
  logic        in_valid_q;
  blic_state_t state_q, state_d;
  logic        out_valid_q;
  logic [OUT_BITS-1:0] out_data_q;
  logic        advance;
  logic        in_take;

  blic_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  blic_step u_step (
    .cfg_i   (cfg),
    .item_i  (item_q),
    .state_i (state_q),
    .state_o (state_d)
  );

  // The input stage moves on whenever the output register is free or drained.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d.mode             = mode_e'(s_axis_tuser);
    item_d.now_ms           = s_axis_tdata[TIME_W-1:0];
    item_d.control_active   = s_axis_tdata[TIME_W];
    item_d.last_activity_ms = s_axis_tdata[2*TIME_W:TIME_W+1];
    item_d.pattern          = s_axis_tdata[2*TIME_W+KIND_W:2*TIME_W+1];
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
    if (in_valid_q && advance) begin
      out_data_q <= {state_d.dark_from_idle, state_d.blinking, state_d.lit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q                <= 1'b0;
      out_valid_q               <= 1'b0;
      state_q.lit               <= 1'b1;
      state_q.blinking          <= 1'b0;
      state_q.dark_from_idle    <= 1'b0;
      state_q.blink_kind        <= '0;
      state_q.phase_count       <= '0;
      state_q.next_phase_time   <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (in_valid_q && advance) begin
        state_q <= state_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_data_q};

endmodule

// ===== verif/backlight_blink_idle_controller_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for backlight_blink_idle_controller_top: a scripted run, then random
// event streams under several timing settings. Needs blic_pkg and the controller RTL.
module backlight_blink_idle_controller_top_test;
  import blic_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned SCRIPT_LEN      = 25;

  // Result word fields, ordered so that backlight_on lands in bit 0.
  typedef struct packed {
    logic idle_dark;
    logic blink_busy;
    logic backlight_on;
  } status_t;

  typedef struct packed {
    blic_item_t ev;
    logic       known;
    status_t    res;
  } script_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  backlight_blink_idle_controller_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predicted controller state and timings.
  blic_cfg_t          timing;
  logic               lit_q;
  logic               blinking_q;
  logic               dark_idle_q;
  logic [KIND_W-1:0]  kind_q;
  logic [PHASE_W-1:0] phase_q;
  logic [TIME_W-1:0]  next_phase_q;

  status_t status_due [$];
  int      mismatches;
  int      words_checked;
  int      cycle_count;
  int      events_by_mode [4];
  int      blink_runs;
  int      blackouts;
  int      settings_used;
  int      send_calm;
  bit      hold_off_req;

  // Walks through reset, idle expiry, wake, a wrapping blink, a restart, a full run that ends
  // dark, a wake during a blink, a phase that still lies ahead, and the unused mode.
  // Known results are {idle_dark, blink_busy, backlight_on}.
  script_row_t script [0:SCRIPT_LEN-1] = '{
    '{'{MODE_NONE,  32'h0000_0000, 1'b0, 32'h0000_0000, 2'd0}, 1'b1, 3'b001},
    '{'{MODE_TIME,  32'h0000_0000, 1'b1, 32'h0000_0000, 2'd0}, 1'b1, 3'b001},
    '{'{MODE_TIME,  32'h0000_EA60, 1'b0, 32'h0000_0000, 2'd0}, 1'b1, 3'b100},
    '{'{MODE_TIME,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 2'd0}, 1'b0, 3'b000},
    '{'{MODE_WAKE,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 2'd3}, 1'b1, 3'b001},
    '{'{MODE_TIME,  32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 2'd3}, 1'b0, 3'b000},
    '{'{MODE_BLINK, 32'hFFFF_FF00, 1'b0, 32'h0000_0000, 2'd1}, 1'b1, 3'b011},
    '{'{MODE_TIME,  32'hFFFF_FF00, 1'b0, 32'hFFFF_FF00, 2'd0}, 1'b0, 3'b000},
    '{'{MODE_TIME,  32'h0000_0100, 1'b0, 32'hFFFF_FF00, 2'd0}, 1'b0, 3'b000},
    '{'{MODE_TIME,  32'h0000_0220, 1'b0, 32'hFFFF_FF00, 2'd0}, 1'b0, 3'b000},
    '{'{MODE_BLINK, 32'h0000_0300, 1'b1, 32'h0000_0000, 2'd3}, 1'b1, 3'b010},
    '{'{MODE_TIME,  32'h0000_0300, 1'b0, 32'h8000_0300, 2'd0}, 1'b0, 3'b000},
    '{'{MODE_TIME,  32'h0000_06E8, 1'b0, 32'h8000_0300, 2'd0}, 1'b0, 3'b000},
    '{'{MODE_TIME,  32'h0000_0AD0, 1'b0, 32'h8000_0300, 2'd0}, 1'b0, 3'b000},
    '{'{MODE_TIME,  32'h0000_0EB8, 1'b0, 32'h8000_0300, 2'd0}, 1'b0, 3'b000},
    '{'{MODE_TIME,  32'h0000_12A0, 1'b0, 32'h8000_0300, 2'd0}, 1'b0, 3'b000},
    '{'{MODE_TIME,  32'h0000_1688, 1'b0, 32'h8000_0300, 2'd0}, 1'b0, 3'b000},
    '{'{MODE_TIME,  32'h0000_1A70, 1'b0, 32'h8000_0300, 2'd0}, 1'b1, 3'b100},
    '{'{MODE_WAKE,  32'h0000_0000, 1'b0, 32'h0000_0000, 2'd0}, 1'b1, 3'b001},
    '{'{MODE_BLINK, 32'h8000_0000, 1'b0, 32'h0000_0000, 2'd0}, 1'b1, 3'b011},
    '{'{MODE_WAKE,  32'h0000_0000, 1'b0, 32'h0000_0000, 2'd0}, 1'b1, 3'b011},
    '{'{MODE_BLINK, 32'h8000_0100, 1'b0, 32'h0000_0000, 2'd2}, 1'b1, 3'b011},
    '{'{MODE_TIME,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 2'd0}, 1'b0, 3'b000},
    '{'{MODE_TIME,  32'h8000_0100, 1'b1, 32'h0000_0000, 2'd0}, 1'b0, 3'b000},
    '{'{MODE_NONE,  32'h1234_5678, 1'b1, 32'h8765_4321, 2'd1}, 1'b0, 3'b000}
  };

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic idle_over(blic_item_t ev);
    logic [TIME_W-1:0] elapsed;
    elapsed = ev.now_ms - ev.last_activity_ms;
    return elapsed >= timing.idle_timeout;
  endfunction

  function automatic logic [TIME_W-1:0] phase_span();
    if (phase_q[0]) return TIME_W'(timing.blink_pause);
    // Out-of-target and mains-absent patterns are the odd codes and get the long on time.
    if (kind_q[0]) return TIME_W'(timing.blink_long_on);
    return TIME_W'(timing.blink_on);
  endfunction

  function automatic void clear_backlight_state();
    timing.idle_timeout  = IDLE_TIMEOUT_RST;
    timing.blink_on      = BLINK_ON_RST;
    timing.blink_long_on = BLINK_LONG_RST;
    timing.blink_pause   = BLINK_PAUSE_RST;
    lit_q        = 1'b1;
    blinking_q   = 1'b0;
    dark_idle_q  = 1'b0;
    kind_q       = '0;
    phase_q      = '0;
    next_phase_q = '0;
  endfunction

  // Advances the predicted controller by one event and returns the status it reports.
  function automatic status_t step_backlight(blic_item_t ev);
    logic [TIME_W-1:0] lag;
    status_t           res;
    case (ev.mode)
      MODE_TIME: begin
        if (blinking_q) begin
          lag = ev.now_ms - next_phase_q;
          // A lag with its top bit set means the phase time still lies ahead.
          if (!lag[TIME_W-1]) begin
            if (phase_q >= PHASE_END) begin
              blinking_q = 1'b0;
              kind_q     = '0;
              blink_runs++;
              if (!ev.control_active && idle_over(ev)) begin
                dark_idle_q = 1'b1;
                lit_q       = 1'b0;
                blackouts++;
              end else begin
                dark_idle_q = 1'b0;
                lit_q       = 1'b1;
              end
            end else begin
              lit_q        = !phase_q[0];
              next_phase_q = ev.now_ms + phase_span();
              phase_q      = phase_q + 1'b1;
            end
          end
        end else if (ev.control_active) begin
          dark_idle_q = 1'b0;
          lit_q       = 1'b1;
        end else if (idle_over(ev)) begin
          if (!dark_idle_q) begin
            dark_idle_q = 1'b1;
            lit_q       = 1'b0;
            blackouts++;
          end
        end else if (!dark_idle_q) begin
          lit_q = 1'b1;
        end
      end
      MODE_BLINK: begin
        kind_q       = ev.pattern;
        phase_q      = '0;
        blinking_q   = 1'b1;
        dark_idle_q  = 1'b0;
        next_phase_q = ev.now_ms;
      end
      MODE_WAKE: begin
        dark_idle_q = 1'b0;
        if (!blinking_q) lit_q = 1'b1;
      end
      default: ;
    endcase
    res.backlight_on = lit_q;
    res.blink_busy   = blinking_q;
    res.idle_dark    = dark_idle_q;
    return res;
  endfunction

  // Offers one event word after a random gap and records its expected status once taken.
  task automatic push_event(input blic_item_t ev, input logic known, input status_t typed);
    int      gap;
    status_t res;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({ev.pattern, ev.last_activity_ms, ev.control_active, ev.now_ms});
    s_axis_tuser  <= ev.mode;
    do @(posedge clk_i); while (!s_axis_tready);
    res = step_backlight(ev);
    status_due.push_back(known ? typed : res);
    events_by_mode[ev.mode]++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
  endtask

  task automatic set_timings(input logic [TIME_W-1:0] idle, input logic [DUR_W-1:0] on_ms,
                             input logic [DUR_W-1:0] long_ms, input logic [DUR_W-1:0] pause_ms);
    write_reg(REG_IDLE_TIMEOUT, idle);
    write_reg(REG_BLINK_ON, CFG_DATA_W'(on_ms));
    write_reg(REG_BLINK_LONG, CFG_DATA_W'(long_ms));
    write_reg(REG_BLINK_PAUSE, CFG_DATA_W'(pause_ms));
    cfg_we_i <= 1'b0;
    timing.idle_timeout  = idle;
    timing.blink_on      = on_ms;
    timing.blink_long_on = long_ms;
    timing.blink_pause   = pause_ms;
    settings_used++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (status_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Random events around a running clock; most time updates move forward a little so that
  // blink runs and idle expiry are reached, the rest are jumps and stray times.
  task automatic random_events(input int count);
    blic_item_t        ev;
    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] prev_last;
    int                r;
    int                s;
    clock_ms  = $urandom;
    prev_last = clock_ms;
    for (int n = 0; n < count; n++) begin
      ev.now_ms           = $urandom;
      ev.control_active   = ($urandom_range(0, 3) == 0);
      ev.last_activity_ms = $urandom;
      ev.pattern          = KIND_W'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 55) begin
        ev.mode = MODE_TIME;
        s = $urandom_range(0, 99);
        if (s < 50) clock_ms += $urandom_range(0, 400);
        else if (s < 80) clock_ms += $urandom_range(0, 2000);
        else if (s < 95) clock_ms += $urandom_range(0, 70000);
        else clock_ms = $urandom;
        ev.now_ms = clock_ms;
        s = $urandom_range(0, 99);
        if (s < 30) ev.last_activity_ms = clock_ms - $urandom_range(0, 100);
        else if (s < 60) ev.last_activity_ms = clock_ms - timing.idle_timeout
                                               + $urandom_range(0, 4) - 2;
        else if (s < 80) ev.last_activity_ms = prev_last;
        prev_last = ev.last_activity_ms;
      end else if (r < 68) begin
        ev.mode   = MODE_BLINK;
        ev.now_ms = clock_ms;
      end else if (r < 83) begin
        ev.mode = MODE_WAKE;
      end else if (r < 88) begin
        ev.mode = MODE_NONE;
      end else begin
        ev.mode = MODE_TIME;
      end
      push_event(ev, 1'b0, '0);
    end
  endtask

  initial begin : receiver
    int stall_left;
    int calm;
    stall_left = 0;
    calm       = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap(calm);
      end
    end
  end

  always @(posedge clk_i) begin
    status_t got;
    status_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = status_t'(m_axis_tdata[2:0]);
      words_checked++;
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result word with nothing expected: backlight_on=%0b blink_busy=%0b idle_dark=%0b",
                   got.backlight_on, got.blink_busy, got.idle_dark);
      end else begin
        want = status_due.pop_front();
        if (got.backlight_on !== want.backlight_on || got.blink_busy !== want.blink_busy ||
            got.idle_dark !== want.idle_dark) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Word %0d: backlight_on %0b/%0b blink_busy %0b/%0b idle_dark %0b/%0b",
                     words_checked, got.backlight_on, want.backlight_on, got.blink_busy,
                     want.blink_busy, got.idle_dark, want.idle_dark);
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_NONE;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_IDLE_TIMEOUT;
    cfg_data_i    = '0;
    hold_off_req  = 1'b0;
    send_calm     = 0;
    mismatches    = 0;
    words_checked = 0;
    cycle_count   = 0;
    blink_runs    = 0;
    blackouts     = 0;
    settings_used = 1;
    events_by_mode = '{default: 0};
    clear_backlight_state();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (script[i]) push_event(script[i].ev, script[i].known, script[i].res);
    drain_results();

    // Mixed extremes, with the receiver holding off long enough to back up the input.
    set_timings(32'd5000, 16'd1, 16'hFFFF, 16'd200);
    hold_off_req = 1'b1;
    random_events(250);
    drain_results();

    // Zero durations and timeout: each phase falls due at the next time update that does not step back.
    set_timings(32'd0, 16'd0, 16'd0, 16'd0);
    random_events(200);
    drain_results();

    set_timings(32'hFFFF_FFFF, 16'hFFFF, 16'd1, 16'hFFFF);
    random_events(200);
    drain_results();

    set_timings(TIME_W'($urandom_range(100, 20000)), DUR_W'($urandom_range(1, 3000)),
                DUR_W'($urandom_range(1, 3000)), DUR_W'($urandom_range(1, 3000)));
    random_events(200);
    drain_results();

    set_timings(IDLE_TIMEOUT_RST, BLINK_ON_RST, BLINK_LONG_RST, BLINK_PAUSE_RST);
    random_events(175);
    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Ran %0d events under %0d timing settings: %0d time updates, %0d blink starts,",
             words_checked, settings_used, events_by_mode[MODE_TIME],
             events_by_mode[MODE_BLINK]);
    $display("%0d activity notices, %0d unused-mode words; %0d blink runs ended, %0d idle blackouts.",
             events_by_mode[MODE_WAKE], events_by_mode[MODE_NONE], blink_runs, blackouts);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
